// File: src/ghash_authenticator_assert.svh
// ---------------------------------------------------------------------------
// GHASH authenticator assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef GHASH_AUTHENTICATOR_ASSERT_SVH
`define GHASH_AUTHENTICATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GH_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("GHASH assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("GHASH assertion failed");

`endif

// File: src/gh_auth_pkg.sv
// ---------------------------------------------------------------------------
// GHASH authenticator package
// Constants, codes and control types shared by the GHASH datapath.
// ---------------------------------------------------------------------------
package gh_auth_pkg;

    localparam int GH_BLOCK_BITS  = 128;
    localparam int GH_BLOCK_BYTES = 16;
    localparam int GH_DIGIT_BITS  = 8;
    localparam int GH_TOTAL_BITS  = 61;
    localparam int GH_COUNT_BITS  = 5;

    // Reduction polynomial in NIST bit order: 0xE1 followed by 120 zero bits.
    localparam logic [GH_BLOCK_BITS-1:0] GH_REDUCE = {8'hE1, {(GH_BLOCK_BITS-8){1'b0}}};

    localparam logic [1:0] CMD_AAD    = 2'd0;
    localparam logic [1:0] CMD_TEXT   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_FIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic start;
    } t_mul_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

endpackage

// File: src/gh_auth_mul.sv
// ---------------------------------------------------------------------------
// GHASH digit-serial multiplier
// Multiplies a 128-bit operand by the hash subkey in GF(2^128), consuming
// one digit of the operand per cycle, most significant digit first.
// ---------------------------------------------------------------------------
module gh_auth_mul #(
    parameter int DIGIT_BITS = gh_auth_pkg::GH_DIGIT_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gh_auth_pkg::t_mul_ctl                  i_ctl,
    input  logic [gh_auth_pkg::GH_BLOCK_BITS-1:0]  i_x,
    input  logic [gh_auth_pkg::GH_BLOCK_BITS-1:0]  i_h,
    output gh_auth_pkg::t_mul_sts                  o_sts,
    output logic [gh_auth_pkg::GH_BLOCK_BITS-1:0]  o_z
);
    import gh_auth_pkg::*;

    localparam int STEPS = GH_BLOCK_BITS / DIGIT_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic [GH_BLOCK_BITS-1:0] r_x, n_x;
    logic [GH_BLOCK_BITS-1:0] r_v, n_v;
    logic [GH_BLOCK_BITS-1:0] r_z, n_z;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_done;

    // One digit of shift-and-add: Z picks up V for each set operand bit,
    // V is multiplied by x with the reduction folded back in.
    always_comb begin
        n_v = r_v;
        n_z = r_z;
        for (int i = 0; i < DIGIT_BITS; i++) begin
            if (r_x[GH_BLOCK_BITS-1-i]) begin
                n_z = n_z ^ n_v;
            end
            n_v = (n_v >> 1) ^ (n_v[0] ? GH_REDUCE : '0);
        end
        n_x = r_x << DIGIT_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x <= i_x;
            r_v <= i_h;
            r_z <= '0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_v <= n_v;
            r_z <= n_z;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_z        = r_z;

`include "ghash_authenticator_assert.svh"

    `GH_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_ctl.start, r_busy)
    `GH_ASSERT_SAME(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy) && !r_busy)
    `GH_ASSERT_NEXT(a_busy_holds, i_clk, i_rst_n, r_busy && (r_cnt != LAST), r_busy)

endmodule

// File: src/ghash_authenticator.sv
// ---------------------------------------------------------------------------
// GHASH authenticator
// The GHASH universal hash of AES-GCM over additional data and ciphertext
// blocks, with a finish command that folds in the length block and emits
// the 128-bit hash.
// ---------------------------------------------------------------------------
// Each data word carries one 128-bit block and a byte count of 1 to 16;
// bytes beyond the count are taken as zero, counts above 16 act as 16, and
// a count of zero or command 3 is accepted and ignored in the same cycle.
// Every block is folded as acc = (acc xor block) * H in GF(2^128), NIST bit
// order, by a digit-serial multiplier that consumes 8 bits per cycle, so a
// data block keeps the block busy until the multiplier is done and the
// accumulator is written back, and only then is a new word taken.
// Finish folds the block lenAAD||lenC (bit lengths, byte totals held modulo
// 2^61), places the hash in the output register and clears the accumulator
// and both totals; the hash subkey is kept. The output register lets the
// next words be accepted while a hash waits to be taken; a second finish is
// folded as usual and then holds the input stalled until the first hash has
// gone. The subkey is written through the configuration port (index 0 for
// the upper half, index 1 for the lower half, both big-endian); the user
// must write it only while the block is idle, which the block itself does
// not enforce. That port is always ready.
// ---------------------------------------------------------------------------
module ghash_authenticator #(
    parameter int DIGIT_BITS = gh_auth_pkg::GH_DIGIT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // Input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_data_high,
    input  logic [63:0] i_data_low,
    input  logic [4:0]  i_byte_count,
    // Result word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_high,
    output logic [63:0] o_hash_low
);
    import gh_auth_pkg::*;

    t_state                   r_state, n_state;
    logic [GH_BLOCK_BITS-1:0] r_key;
    logic [GH_BLOCK_BITS-1:0] r_acc;
    logic [GH_TOTAL_BITS-1:0] r_aad_total;
    logic [GH_TOTAL_BITS-1:0] r_text_total;
    logic [GH_BLOCK_BITS-1:0] r_out;
    logic                     r_out_valid;

    logic                     in_take;
    logic                     out_take;
    logic                     emit_go;
    logic                     in_fold;
    logic [GH_COUNT_BITS-1:0] count_sat;
    logic [GH_BLOCK_BITS-1:0] block_mask;
    logic [GH_BLOCK_BITS-1:0] data_block;
    logic [GH_BLOCK_BITS-1:0] len_block;
    logic                     is_data;
    logic                     is_finish;
    t_mul_ctl                 mul_ctl;
    t_mul_sts                 mul_sts;
    logic [GH_BLOCK_BITS-1:0] mul_x;
    logic [GH_BLOCK_BITS-1:0] mul_z;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign emit_go     = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign in_fold     = (r_state == S_MUL) || (r_state == S_FIN);

    // Byte count saturates at a full block; the mask keeps the leading bytes.
    always_comb begin
        count_sat = (i_byte_count > GH_COUNT_BITS'(GH_BLOCK_BYTES))
                  ? GH_COUNT_BITS'(GH_BLOCK_BYTES) : i_byte_count;
        for (int j = 0; j < GH_BLOCK_BYTES; j++) begin
            block_mask[GH_BLOCK_BITS-1-8*j -: 8] =
                (GH_COUNT_BITS'(j) < count_sat) ? 8'hFF : 8'h00;
        end
    end

    assign data_block = {i_data_high, i_data_low} & block_mask;
    assign len_block  = {r_aad_total, 3'b000, r_text_total, 3'b000};
    assign is_finish  = (i_command == CMD_FINISH);
    assign is_data    = ((i_command == CMD_AAD) || (i_command == CMD_TEXT))
                     && (i_byte_count != '0);

    assign mul_ctl.start = in_take && (is_data || is_finish);
    assign mul_x         = r_acc ^ (is_finish ? len_block : data_block);

    gh_auth_mul #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_x     (mul_x),
        .i_h     (r_key),
        .o_sts   (mul_sts),
        .o_z     (mul_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (mul_ctl.start) begin
                    n_state = is_finish ? S_FIN : S_MUL;
                end
            end
            S_MUL: begin
                if (mul_sts.done) begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (mul_sts.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Accumulator, byte totals and subkey.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key        <= '0;
            r_acc        <= '0;
            r_aad_total  <= '0;
            r_text_total <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_KEY_HIGH) begin
                    r_key[GH_BLOCK_BITS-1 -: 64] <= i_cfg_data;
                end else begin
                    r_key[63:0] <= i_cfg_data;
                end
            end
            if (mul_sts.done) begin
                r_acc <= mul_z;
            end else if (emit_go) begin
                r_acc <= '0;
            end
            if (in_take && is_finish) begin
                r_aad_total  <= '0;
                r_text_total <= '0;
            end else if (in_take && is_data && (i_command == CMD_AAD)) begin
                r_aad_total <= r_aad_total + GH_TOTAL_BITS'(count_sat);
            end else if (in_take && is_data) begin
                r_text_total <= r_text_total + GH_TOTAL_BITS'(count_sat);
            end
        end
    end

    // Output register: a finished hash waits here until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out <= r_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hash_high = r_out[GH_BLOCK_BITS-1 -: 64];
    assign o_hash_low  = r_out[63:0];

`include "ghash_authenticator_assert.svh"

    `GH_ASSERT_SAME(a_start_when_free, i_clk, i_rst_n, mul_ctl.start, !mul_sts.busy)
    `GH_ASSERT_SAME(a_done_in_fold, i_clk, i_rst_n, mul_sts.done, in_fold)
    `GH_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, emit_go, r_out_valid && (r_acc == '0))

endmodule
